@@ src/lsu_pkg.sv @@
// Shared types, codes and helpers of the load/store unit.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lsu_pkg;

  localparam int MEM_DEPTH_DEF = 65536;

  // item commands
  localparam logic [1:0] CMD_WR   = 2'd0;
  localparam logic [1:0] CMD_EXEC = 2'd1;
  localparam logic [1:0] CMD_RD   = 2'd2;

  // instruction forms
  localparam logic [4:0] OP_R_R      = 5'd0;
  localparam logic [4:0] OP_R_N      = 5'd1;
  localparam logic [4:0] OP_R_PRR    = 5'd2;
  localparam logic [4:0] OP_PRR_R    = 5'd3;
  localparam logic [4:0] OP_PRR_N    = 5'd4;
  localparam logic [4:0] OP_R_PNN    = 5'd5;
  localparam logic [4:0] OP_PNN_R    = 5'd6;
  localparam logic [4:0] OP_R_HIR    = 5'd7;
  localparam logic [4:0] OP_HIR_R    = 5'd8;
  localparam logic [4:0] OP_R_HIN    = 5'd9;
  localparam logic [4:0] OP_HIN_R    = 5'd10;
  localparam logic [4:0] OP_RR_NN    = 5'd11;
  localparam logic [4:0] OP_PNN_RR   = 5'd12;
  localparam logic [4:0] OP_RR_RR    = 5'd13;
  localparam logic [4:0] OP_PUSH     = 5'd14;
  localparam logic [4:0] OP_POP      = 5'd15;
  localparam logic [4:0] OP_POP_AF   = 5'd16;

  // byte register indexes
  localparam logic [2:0] R_B = 3'd0;
  localparam logic [2:0] R_C = 3'd1;
  localparam logic [2:0] R_D = 3'd2;
  localparam logic [2:0] R_E = 3'd3;
  localparam logic [2:0] R_H = 3'd4;
  localparam logic [2:0] R_L = 3'd5;
  localparam logic [2:0] R_A = 3'd6;
  localparam logic [2:0] R_F = 3'd7;

  // pair indexes
  localparam logic [2:0] P_BC = 3'd0;
  localparam logic [2:0] P_DE = 3'd1;
  localparam logic [2:0] P_HL = 3'd2;
  localparam logic [2:0] P_SP = 3'd3;
  localparam logic [2:0] P_AF = 3'd4;

  // post modes
  localparam logic [1:0] PM_INC = 2'd1;
  localparam logic [1:0] PM_DEC = 2'd2;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;
  localparam logic [7:0]  FLAG_MASK = 8'hF0;

  // sequencer steps
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_IMM1  = 4'd1;
  localparam logic [3:0] ST_IMM1C = 4'd2;
  localparam logic [3:0] ST_IMM2  = 4'd3;
  localparam logic [3:0] ST_IMM2C = 4'd4;
  localparam logic [3:0] ST_ACC1  = 4'd5;
  localparam logic [3:0] ST_ACC1C = 4'd6;
  localparam logic [3:0] ST_ACC2  = 4'd7;
  localparam logic [3:0] ST_ACC2C = 4'd8;
  localparam logic [3:0] ST_WB    = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  typedef logic [7:0][7:0] byte_file_t;

  typedef struct packed {
    byte_file_t  g;
    logic [15:0] sp;
  } rf_t;

  typedef struct packed {
    logic [3:0] step;
    logic       take;
    logic       mem_re;
    logic       mem_we;
  } ctl_t;

  function automatic logic [15:0] pair_get(rf_t rf, logic [2:0] sel);
    logic [15:0] v;
    case (sel)
      P_BC:    v = {rf.g[R_B], rf.g[R_C]};
      P_DE:    v = {rf.g[R_D], rf.g[R_E]};
      P_HL:    v = {rf.g[R_H], rf.g[R_L]};
      P_SP:    v = rf.sp;
      P_AF:    v = {rf.g[R_A], rf.g[R_F]};
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic rf_t pair_set(rf_t rf, logic [2:0] sel, logic [15:0] v);
    rf_t r;
    r = rf;
    case (sel)
      P_BC: begin r.g[R_B] = v[15:8]; r.g[R_C] = v[7:0]; end
      P_DE: begin r.g[R_D] = v[15:8]; r.g[R_E] = v[7:0]; end
      P_HL: begin r.g[R_H] = v[15:8]; r.g[R_L] = v[7:0]; end
      P_SP: r.sp = v;
      P_AF: begin r.g[R_A] = v[15:8]; r.g[R_F] = v[7:0]; end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] op_len(logic [4:0] k);
    logic [1:0] n;
    case (k)
      OP_R_N, OP_PRR_N, OP_R_HIN, OP_HIN_R:        n = 2'd2;
      OP_R_PNN, OP_PNN_R, OP_RR_NN, OP_PNN_RR:     n = 2'd3;
      default:                                     n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

@@ src/lsu_if.sv @@
// Handshake channels of the load/store unit: item in, register file out.
// Depends on nothing beyond plain logic types.
`timescale 1ns / 1ps

interface lsu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [4:0]  op_kind;
  logic [2:0]  dst_sel;
  logic [2:0]  src_sel;
  logic [1:0]  post_mode;
  logic [15:0] mem_addr;
  logic [7:0]  mem_data;

  modport source (output valid, cmd, op_kind, dst_sel, src_sel, post_mode, mem_addr,
                  mem_data, input ready);
  modport sink (input valid, cmd, op_kind, dst_sel, src_sel, post_mode, mem_addr,
                mem_data, output ready);
endinterface

interface lsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_a;
  logic [7:0]  out_f;
  logic [7:0]  out_b;
  logic [7:0]  out_c;
  logic [7:0]  out_d;
  logic [7:0]  out_e;
  logic [7:0]  out_h;
  logic [7:0]  out_l;
  logic [15:0] out_sp;
  logic [15:0] out_pc;
  logic [7:0]  peek_data;

  modport source (output valid, out_a, out_f, out_b, out_c, out_d, out_e, out_h, out_l,
                  out_sp, out_pc, peek_data, input ready);
  modport sink (input valid, out_a, out_f, out_b, out_c, out_d, out_e, out_h, out_l,
                out_sp, out_pc, peek_data, output ready);
endinterface

@@ src/lsu_ctrl.sv @@
// Sequencer of the load/store unit: walks immediate fetch, memory access,
// write-back and result steps. Uses lsu_pkg.
`timescale 1ns / 1ps

module lsu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_cmd,
  input  logic [4:0]    in_op_kind,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lsu_pkg::ctl_t ctl
);

  logic [3:0] state_r, state_nxt;
  logic [1:0] cmd_r;
  logic [4:0] kind_r;
  logic       ex, f_imm2, f_acc1, f_rd1, f_acc2, f_rd2;

  always_comb begin
    ex     = (cmd_r == lsu_pkg::CMD_EXEC) && (kind_r <= lsu_pkg::OP_POP_AF);
    f_imm2 = ex && (kind_r inside {lsu_pkg::OP_R_PNN, lsu_pkg::OP_PNN_R,
                                   lsu_pkg::OP_RR_NN, lsu_pkg::OP_PNN_RR});
    f_rd1  = (cmd_r == lsu_pkg::CMD_RD)
          || (ex && (kind_r inside {lsu_pkg::OP_R_PRR, lsu_pkg::OP_R_PNN, lsu_pkg::OP_R_HIR,
                                    lsu_pkg::OP_R_HIN, lsu_pkg::OP_POP,
                                    lsu_pkg::OP_POP_AF}));
    f_acc1 = (cmd_r == lsu_pkg::CMD_WR) || f_rd1
          || (ex && (kind_r inside {lsu_pkg::OP_PRR_R, lsu_pkg::OP_PRR_N, lsu_pkg::OP_PNN_R,
                                    lsu_pkg::OP_HIR_R, lsu_pkg::OP_HIN_R,
                                    lsu_pkg::OP_PNN_RR, lsu_pkg::OP_PUSH}));
    f_rd2  = ex && (kind_r inside {lsu_pkg::OP_POP, lsu_pkg::OP_POP_AF});
    f_acc2 = f_rd2 || (ex && (kind_r inside {lsu_pkg::OP_PNN_RR, lsu_pkg::OP_PUSH}));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsu_pkg::ST_IDLE:  if (in_valid) state_nxt = lsu_pkg::ST_IMM1;
      lsu_pkg::ST_IMM1:  state_nxt = lsu_pkg::ST_IMM1C;
      lsu_pkg::ST_IMM1C: state_nxt = f_imm2 ? lsu_pkg::ST_IMM2 :
                                     f_acc1 ? lsu_pkg::ST_ACC1 : lsu_pkg::ST_WB;
      lsu_pkg::ST_IMM2:  state_nxt = lsu_pkg::ST_IMM2C;
      lsu_pkg::ST_IMM2C: state_nxt = f_acc1 ? lsu_pkg::ST_ACC1 : lsu_pkg::ST_WB;
      lsu_pkg::ST_ACC1:  state_nxt = f_rd1  ? lsu_pkg::ST_ACC1C :
                                     f_acc2 ? lsu_pkg::ST_ACC2 : lsu_pkg::ST_WB;
      lsu_pkg::ST_ACC1C: state_nxt = f_acc2 ? lsu_pkg::ST_ACC2 : lsu_pkg::ST_WB;
      lsu_pkg::ST_ACC2:  state_nxt = f_rd2  ? lsu_pkg::ST_ACC2C : lsu_pkg::ST_WB;
      lsu_pkg::ST_ACC2C: state_nxt = lsu_pkg::ST_WB;
      lsu_pkg::ST_WB:    state_nxt = lsu_pkg::ST_OUT;
      lsu_pkg::ST_OUT:   if (out_ready) state_nxt = lsu_pkg::ST_IDLE;
      default:           state_nxt = lsu_pkg::ST_IDLE;
    endcase
    // the item's flags are not latched yet in IDLE; pick the first step here
    if (state_r == lsu_pkg::ST_IDLE && in_valid) begin
      if (in_cmd == lsu_pkg::CMD_EXEC && (in_op_kind inside {lsu_pkg::OP_R_N,
          lsu_pkg::OP_PRR_N, lsu_pkg::OP_R_PNN, lsu_pkg::OP_PNN_R, lsu_pkg::OP_R_HIN,
          lsu_pkg::OP_HIN_R, lsu_pkg::OP_RR_NN, lsu_pkg::OP_PNN_RR}))
        state_nxt = lsu_pkg::ST_IMM1;
      else if (in_cmd == lsu_pkg::CMD_WR || in_cmd == lsu_pkg::CMD_RD
               || (in_cmd == lsu_pkg::CMD_EXEC
                   && (in_op_kind inside {lsu_pkg::OP_R_PRR, lsu_pkg::OP_PRR_R,
                       lsu_pkg::OP_R_HIR, lsu_pkg::OP_HIR_R, lsu_pkg::OP_PUSH,
                       lsu_pkg::OP_POP, lsu_pkg::OP_POP_AF})))
        state_nxt = lsu_pkg::ST_ACC1;
      else
        state_nxt = lsu_pkg::ST_WB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r  <= in_cmd;
      kind_r <= in_op_kind;
    end
  end

  assign in_ready   = (state_r == lsu_pkg::ST_IDLE);
  assign out_valid  = (state_r == lsu_pkg::ST_OUT);

  always_comb begin
    ctl.step   = state_r;
    ctl.take   = in_ready && in_valid;
    ctl.mem_re = (state_r == lsu_pkg::ST_IMM1) || (state_r == lsu_pkg::ST_IMM2)
              || (state_r == lsu_pkg::ST_ACC1 && f_rd1)
              || (state_r == lsu_pkg::ST_ACC2 && f_rd2);
    ctl.mem_we = (state_r == lsu_pkg::ST_ACC1 && !f_rd1)
              || (state_r == lsu_pkg::ST_ACC2 && !f_rd2);
  end

endmodule

@@ src/lsu_dpath.sv @@
// Datapath of the load/store unit: register file, SP, PC, byte memory,
// address and write-data selection, write-back. Uses lsu_pkg.
`timescale 1ns / 1ps

module lsu_dpath #(
  parameter int MEM_DEPTH = lsu_pkg::MEM_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lsu_pkg::ctl_t ctl,
  input  logic [1:0]    in_cmd,
  input  logic [4:0]    in_op_kind,
  input  logic [2:0]    in_dst_sel,
  input  logic [2:0]    in_src_sel,
  input  logic [1:0]    in_post_mode,
  input  logic [15:0]   in_mem_addr,
  input  logic [7:0]    in_mem_data,
  output lsu_pkg::rf_t  rf,
  output logic [15:0]   pc,
  output logic [7:0]    peek
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] mem_q_r;

  lsu_pkg::rf_t rf_r, rf_nxt;
  logic [15:0]  pc_r, pc_nxt;
  logic [7:0]   peek_r, peek_nxt;

  logic [1:0]  cmd_r, pm_r;
  logic [4:0]  kind_r;
  logic [2:0]  d_r, s_r;
  logic [15:0] addr_in_r;
  logic [7:0]  data_in_r;
  logic [7:0]  imm_lo_r, imm_hi_r, d0_r, d1_r;

  logic [15:0] imm16, pd, ps, maddr, adj;
  logic [7:0]  wdata;

  assign imm16 = {imm_hi_r, imm_lo_r};
  assign pd    = lsu_pkg::pair_get(rf_r, d_r);
  assign ps    = lsu_pkg::pair_get(rf_r, s_r);

  always_comb begin
    maddr = 16'h0000;
    wdata = 8'h00;
    unique case (ctl.step)
      lsu_pkg::ST_IMM1: maddr = pc_r + 16'd1;
      lsu_pkg::ST_IMM2: maddr = pc_r + 16'd2;
      lsu_pkg::ST_ACC1: begin
        if (cmd_r != lsu_pkg::CMD_EXEC) begin
          maddr = addr_in_r;
          wdata = data_in_r;
        end else begin
          wdata = rf_r.g[s_r];
          case (kind_r)
            lsu_pkg::OP_R_PRR:  maddr = ps;
            lsu_pkg::OP_PRR_R:  maddr = pd;
            lsu_pkg::OP_PRR_N: begin maddr = pd; wdata = imm_lo_r; end
            lsu_pkg::OP_R_HIR:  maddr = lsu_pkg::HIGH_PAGE | {8'h00, rf_r.g[s_r]};
            lsu_pkg::OP_HIR_R:  maddr = lsu_pkg::HIGH_PAGE | {8'h00, rf_r.g[d_r]};
            lsu_pkg::OP_R_HIN, lsu_pkg::OP_HIN_R:
              maddr = lsu_pkg::HIGH_PAGE | {8'h00, imm_lo_r};
            lsu_pkg::OP_PNN_RR: begin maddr = imm16; wdata = ps[7:0]; end
            lsu_pkg::OP_PUSH:   begin maddr = rf_r.sp - 16'd1; wdata = ps[15:8]; end
            lsu_pkg::OP_POP, lsu_pkg::OP_POP_AF: maddr = rf_r.sp;
            default:            maddr = imm16;
          endcase
        end
      end
      lsu_pkg::ST_ACC2: begin
        case (kind_r)
          lsu_pkg::OP_PNN_RR: begin maddr = imm16 + 16'd1; wdata = ps[15:8]; end
          lsu_pkg::OP_PUSH:   begin maddr = rf_r.sp - 16'd2; wdata = ps[7:0]; end
          default:            maddr = rf_r.sp + 16'd1;
        endcase
      end
      default: ;
    endcase
  end

  // single-port byte memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.mem_we) mem[maddr[AW-1:0]] <= wdata;
    if (ctl.mem_re) mem_q_r <= mem[maddr[AW-1:0]];
  end

  always_comb begin
    rf_nxt   = rf_r;
    pc_nxt   = pc_r;
    peek_nxt = peek_r;
    adj      = 16'h0000;
    if (ctl.step == lsu_pkg::ST_WB) begin
      peek_nxt = (cmd_r == lsu_pkg::CMD_RD) ? d0_r : 8'h00;
      if (cmd_r == lsu_pkg::CMD_EXEC && kind_r <= lsu_pkg::OP_POP_AF) begin
        pc_nxt = pc_r + {14'd0, lsu_pkg::op_len(kind_r)};
        case (kind_r)
          lsu_pkg::OP_R_R: rf_nxt.g[d_r] = rf_r.g[s_r];
          lsu_pkg::OP_R_N: rf_nxt.g[d_r] = imm_lo_r;
          lsu_pkg::OP_R_PRR: begin
            // loaded byte lands first, then the pointer moves
            rf_nxt.g[d_r] = d0_r;
            adj = lsu_pkg::pair_get(rf_nxt, s_r);
            if (pm_r == lsu_pkg::PM_INC)
              rf_nxt = lsu_pkg::pair_set(rf_nxt, s_r, adj + 16'd1);
            else if (pm_r == lsu_pkg::PM_DEC)
              rf_nxt = lsu_pkg::pair_set(rf_nxt, s_r, adj - 16'd1);
          end
          lsu_pkg::OP_PRR_R: begin
            if (pm_r == lsu_pkg::PM_INC)
              rf_nxt = lsu_pkg::pair_set(rf_r, d_r, pd + 16'd1);
            else if (pm_r == lsu_pkg::PM_DEC)
              rf_nxt = lsu_pkg::pair_set(rf_r, d_r, pd - 16'd1);
          end
          lsu_pkg::OP_R_PNN, lsu_pkg::OP_R_HIR, lsu_pkg::OP_R_HIN:
            rf_nxt.g[d_r] = d0_r;
          lsu_pkg::OP_RR_NN: rf_nxt = lsu_pkg::pair_set(rf_r, d_r, imm16);
          lsu_pkg::OP_RR_RR: rf_nxt = lsu_pkg::pair_set(rf_r, d_r, ps);
          lsu_pkg::OP_PUSH:  rf_nxt.sp = rf_r.sp - 16'd2;
          lsu_pkg::OP_POP: begin
            rf_nxt.sp = rf_r.sp + 16'd2;
            rf_nxt = lsu_pkg::pair_set(rf_nxt, d_r, {d1_r, d0_r});
          end
          lsu_pkg::OP_POP_AF: begin
            rf_nxt.sp = rf_r.sp + 16'd2;
            rf_nxt = lsu_pkg::pair_set(rf_nxt, lsu_pkg::P_AF,
                                       {d1_r, d0_r & lsu_pkg::FLAG_MASK});
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r   <= '0;
      pc_r   <= 16'h0000;
      peek_r <= 8'h00;
    end else begin
      rf_r   <= rf_nxt;
      pc_r   <= pc_nxt;
      peek_r <= peek_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r     <= in_cmd;
      kind_r    <= in_op_kind;
      d_r       <= in_dst_sel;
      s_r       <= in_src_sel;
      pm_r      <= in_post_mode;
      addr_in_r <= in_mem_addr;
      data_in_r <= in_mem_data;
    end
    if (ctl.step == lsu_pkg::ST_IMM1C) imm_lo_r <= mem_q_r;
    if (ctl.step == lsu_pkg::ST_IMM2C) imm_hi_r <= mem_q_r;
    if (ctl.step == lsu_pkg::ST_ACC1C) d0_r     <= mem_q_r;
    if (ctl.step == lsu_pkg::ST_ACC2C) d1_r     <= mem_q_r;
  end

  assign rf   = rf_r;
  assign pc   = pc_r;
  assign peek = peek_r;

endmodule

@@ src/cpu_load_store_unit.sv @@
// Load/store unit of an 8-bit CPU: top level joining sequencer and datapath.
// Depends on lsu_pkg, lsu_if, lsu_ctrl and lsu_dpath.
`timescale 1ns / 1ps

// One item at a time. An item is accepted in IDLE, then walks its steps:
// each byte read on the single-port memory takes an access step and a
// capture step, each byte written one access step (immediates at PC+1/PC+2
// count as reads), then one write-back step and one step to present the
// result. A plain register move goes straight from acceptance to write-back.
// The result holds the whole register file after the item and stays until
// taken; the next item is accepted in the cycle after. Memory is not cleared
// at reset; MEM_DEPTH must be a power of two and addresses wrap on it.
module cpu_load_store_unit #(
  parameter int MEM_DEPTH = lsu_pkg::MEM_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lsu_in_if.sink    in_ch,
  lsu_out_if.source out_ch
);

  lsu_pkg::ctl_t ctl;
  lsu_pkg::rf_t  rf;
  logic [15:0]   pc;
  logic [7:0]    peek;
  logic          in_ready, out_valid;

  lsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .in_op_kind (in_ch.op_kind),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .ctl        (ctl)
  );

  lsu_dpath #(.MEM_DEPTH(MEM_DEPTH)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .in_cmd       (in_ch.cmd),
    .in_op_kind   (in_ch.op_kind),
    .in_dst_sel   (in_ch.dst_sel),
    .in_src_sel   (in_ch.src_sel),
    .in_post_mode (in_ch.post_mode),
    .in_mem_addr  (in_ch.mem_addr),
    .in_mem_data  (in_ch.mem_data),
    .rf           (rf),
    .pc           (pc),
    .peek         (peek)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.out_a     = rf.g[lsu_pkg::R_A];
  assign out_ch.out_f     = rf.g[lsu_pkg::R_F];
  assign out_ch.out_b     = rf.g[lsu_pkg::R_B];
  assign out_ch.out_c     = rf.g[lsu_pkg::R_C];
  assign out_ch.out_d     = rf.g[lsu_pkg::R_D];
  assign out_ch.out_e     = rf.g[lsu_pkg::R_E];
  assign out_ch.out_h     = rf.g[lsu_pkg::R_H];
  assign out_ch.out_l     = rf.g[lsu_pkg::R_L];
  assign out_ch.out_sp    = rf.sp;
  assign out_ch.out_pc    = pc;
  assign out_ch.peek_data = peek;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("result offered while taking a new item");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |=> !in_ready)
    else $error("ready right after accepting an item");

  a_pc_only_at_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step != lsu_pkg::ST_WB) |=> $stable(pc))
    else $error("PC moved outside write-back");

  a_mem_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.mem_re && ctl.mem_we))
    else $error("memory read and write in the same cycle");

endmodule
